// ===== hw/rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// shared types and constants for the triangle face normal emitter
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int CW = COORD_WIDTH;
    localparam int NORM_BITS = 16;
    localparam logic [15:0] ONE_Q14 = 16'd16384;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic                 new_mesh;
    } t_tri_in;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] pos_z;
        logic signed [15:0]   norm_x;
        logic signed [15:0]   norm_y;
        logic signed [15:0]   norm_z;
        logic [31:0]          vertex_index;
        logic                 last;
    } t_vtx_out;

    typedef struct packed {
        t_tri_in     tri_data;
        logic [31:0] base_index;
    } t_queue_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_MUL, ST_CROSS, ST_NORM, ST_SQ, ST_SUM, ST_SEARCH, ST_EMIT
    } t_back_state;

endpackage

// ===== hw/rtl/triangle_face_normal_emit.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_emit
// unit face normal per triangle, emitted with each of its three vertices
// ----------------------------------------------------------------------------
// A triangle is taken into a two-entry queue whenever the queue has room. The
// back end fetches from the queue, then works through edges, products, cross
// product, scaling, squares and sum, then a bisection of 14 or 15 steps per
// normal component, each step a square, a product with the sum and a compare
// through the shared multipliers, storing each component when it is found,
// then outputs the three vertices (a, b, c) with last on c, holding while the
// output is stalled. A degenerate triangle skips squares, sum and search.
module triangle_face_normal_emit
    import tfn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_tri_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_vtx_out o_data
);
    logic        w_push, w_full, w_pop, w_empty;
    t_queue_item w_in, w_out;

    tfn_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_push(w_push), .o_item(w_in), .i_full(w_full)
    );

    tfn_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_item(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_item(w_out)
    );

    tfn_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_item(w_out), .o_pop(w_pop),
        .o_valid, .i_stall, .o_data
    );
endmodule

// ===== hw/rtl/tfn_front.sv =====
// ----------------------------------------------------------------------------
// tfn_front
// accepts triangles, assigns the base vertex index, feeds the queue
// ----------------------------------------------------------------------------
module tfn_front
    import tfn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_tri_in     i_data,
    output logic        o_push,
    output t_queue_item o_item,
    input  logic        i_full
);
    logic [31:0] r_next;
    logic [31:0] n_base;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign n_base  = i_data.new_mesh ? 32'd0 : r_next;
    assign o_item  = '{tri_data: i_data, base_index: n_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
        end else if (o_push) begin
            r_next <= n_base + 32'd3;
        end
    end
endmodule

// ===== hw/rtl/tfn_queue.sv =====
// ----------------------------------------------------------------------------
// tfn_queue
// small fifo between front and back
// ----------------------------------------------------------------------------
module tfn_queue
    import tfn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_queue_item i_item,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output t_queue_item o_item
);
    t_queue_item r_mem [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QUEUE_DEPTH):0]   r_cnt;

    assign o_full  = r_cnt == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end
endmodule

// ===== hw/rtl/tfn_back.sv =====
// ----------------------------------------------------------------------------
// tfn_back
// cross product, block scaling, per-component rounding search, vertex emit
// ----------------------------------------------------------------------------
module tfn_back
    import tfn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_queue_item i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_vtx_out    o_data
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int SH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
    localparam int EW = DW - SH;
    localparam int PW = 2 * EW;

    t_back_state r_st, n_st;
    t_queue_item r_it;
    logic signed [EW-1:0] r_u [3];
    logic signed [EW-1:0] r_v [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [PW:0]   r_cr [3];
    logic [PW:0]          r_mg [3];
    logic [31:0]          r_sq [3];
    logic [33:0]          r_s;
    logic [15:0]          r_q [3];
    logic [15:0]          r_lo, r_hi;
    logic [1:0]           r_ci, r_k;
    logic [1:0]           r_mc;
    logic [31:0]          r_rhs;
    logic [33:0]          r_t2;
    logic [63:0]          r_lhs;
    logic                 r_zero;
    logic [7:0]           r_shift;

    function automatic logic signed [EW-1:0] edge_d(logic signed [COORD_WIDTH-1:0] p,
                                                    logic signed [COORD_WIDTH-1:0] q);
        logic signed [DW-1:0] d;
        logic [DW-1:0] m;
        d = DW'(p) - DW'(q);
        m = d[DW-1] ? DW'(-d) : DW'(d);
        m = m >> SH;
        return d[DW-1] ? -EW'(m) : EW'(m);
    endfunction

    logic [PW:0] w_big;
    logic [7:0]  w_bl;
    logic [16:0] w_mid;
    logic [33:0] w_t;
    always_comb begin
        w_big = r_mg[0];
        if (r_mg[1] > w_big) w_big = r_mg[1];
        if (r_mg[2] > w_big) w_big = r_mg[2];
        w_bl = '0;
        for (int i = 0; i <= PW; i++) if (w_big[i]) w_bl = 8'(i + 1);
        w_mid = (17'(r_lo) + 17'(r_hi) + 17'd1) >> 1;
        w_t = {17'd0, w_mid} * 34'd2 - 34'd1;
    end

    always_comb begin
        o_data.pos_x = r_k == 2'd0 ? r_it.tri_data.ax :
                       r_k == 2'd1 ? r_it.tri_data.bx : r_it.tri_data.cx;
        o_data.pos_y = r_k == 2'd0 ? r_it.tri_data.ay :
                       r_k == 2'd1 ? r_it.tri_data.by : r_it.tri_data.cy;
        o_data.pos_z = r_k == 2'd0 ? r_it.tri_data.az :
                       r_k == 2'd1 ? r_it.tri_data.bz : r_it.tri_data.cz;
        o_data.norm_x = r_cr[0][PW] ? -r_q[0] : r_q[0];
        o_data.norm_y = r_cr[1][PW] ? -r_q[1] : r_q[1];
        o_data.norm_z = r_cr[2][PW] ? -r_q[2] : r_q[2];
        if (r_zero) begin
            o_data.norm_x = '0;
            o_data.norm_y = ONE_Q14;
            o_data.norm_z = '0;
        end
        o_data.vertex_index = r_it.base_index + {30'd0, r_k};
        o_data.last = r_k == 2'd2;
    end

    assign o_valid = r_st == ST_EMIT;
    assign o_pop = (r_st == ST_IDLE) && !i_empty;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:   if (!i_empty) n_st = ST_DIFF;
            ST_DIFF:   n_st = ST_MUL;
            ST_MUL:    n_st = ST_CROSS;
            ST_CROSS:  n_st = ST_NORM;
            ST_NORM:   n_st = (w_big == '0) ? ST_EMIT : ST_SQ;
            ST_SQ:     n_st = ST_SUM;
            ST_SUM:    n_st = ST_SEARCH;
            ST_SEARCH: if (r_lo == r_hi && r_ci == 2'd2 && r_mc == 2'd0) n_st = ST_EMIT;
            ST_EMIT:   if (!i_stall && r_k == 2'd2) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_it <= i_item;
                r_k <= '0;
            end
            ST_DIFF: begin
                r_u[0] <= edge_d(r_it.tri_data.bx, r_it.tri_data.ax);
                r_u[1] <= edge_d(r_it.tri_data.by, r_it.tri_data.ay);
                r_u[2] <= edge_d(r_it.tri_data.bz, r_it.tri_data.az);
                r_v[0] <= edge_d(r_it.tri_data.cx, r_it.tri_data.ax);
                r_v[1] <= edge_d(r_it.tri_data.cy, r_it.tri_data.ay);
                r_v[2] <= edge_d(r_it.tri_data.cz, r_it.tri_data.az);
            end
            ST_MUL: begin
                r_p[0] <= r_u[1] * r_v[2];
                r_p[1] <= r_u[2] * r_v[1];
                r_p[2] <= r_u[2] * r_v[0];
                r_p[3] <= r_u[0] * r_v[2];
                r_p[4] <= r_u[0] * r_v[1];
                r_p[5] <= r_u[1] * r_v[0];
            end
            ST_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    r_cr[i] <= (PW+1)'(r_p[2*i]) - (PW+1)'(r_p[2*i+1]);
                    r_mg[i] <= ((PW+1)'(r_p[2*i]) - (PW+1)'(r_p[2*i+1])) >= 0 ?
                        (PW+1)'(r_p[2*i]) - (PW+1)'(r_p[2*i+1]) :
                        (PW+1)'(r_p[2*i+1]) - (PW+1)'(r_p[2*i]);
                end
            end
            ST_NORM: begin
                r_zero <= w_big == '0;
                r_shift <= (w_bl > 8'd16) ? w_bl - 8'd16 : 8'd0;
            end
            ST_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i] <= 16'(r_mg[i] >> r_shift) * 16'(r_mg[i] >> r_shift);
                end
            end
            ST_SUM: begin
                r_s <= 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
                r_ci <= '0;
                r_lo <= '0;
                r_hi <= ONE_Q14;
                r_rhs <= r_sq[0];
                r_mc <= '0;
            end
            ST_SEARCH: begin
                // search step: t*t, then times sum, then compare
                case (r_mc)
                    2'd0: begin
                        if (r_lo == r_hi) begin
                            r_q[r_ci] <= r_lo;
                            r_ci <= r_ci + 2'd1;
                            r_lo <= '0;
                            r_hi <= ONE_Q14;
                            r_rhs <= r_sq[(r_ci == 2'd2) ? 2'd2 : r_ci + 2'd1];
                        end else begin
                            r_t2 <= w_t * w_t;
                            r_mc <= 2'd1;
                        end
                    end
                    2'd1: begin
                        r_lhs <= 64'(r_t2) * 64'(r_s);
                        r_mc <= 2'd2;
                    end
                    default: begin
                        if (r_lhs <= {2'd0, r_rhs, 30'd0}) r_lo <= w_mid[15:0];
                        else r_hi <= w_mid[15:0] - 16'd1;
                        r_mc <= 2'd0;
                    end
                endcase
            end
            ST_EMIT: if (!i_stall) r_k <= r_k + 2'd1;
            default: ;
        endcase
    end
endmodule
